// ===== rtl/core/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants for the voxel label face-contact scan.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int LW    = 16;   // label width on the ports
  localparam int IDX_W = 28;   // raster index width
  localparam int ZW    = 12;   // plane coordinate width
  localparam int ZCW   = 13;   // size_z register width
  localparam int XRW   = 9;    // size_x / size_y register width
  localparam int CFG_W = 13;   // config write data width
  localparam int MAX_Z = 4096;
  localparam int NDIR  = 6;
  localparam int OUT_W = 152;  // result word, padded to bytes

  typedef enum logic [2:0] {
    CFG_SIZE_X   = 3'd0,
    CFG_SIZE_Y   = 3'd1,
    CFG_SIZE_Z   = 3'd2,
    CFG_BOUNDARY = 3'd3,
    CFG_SURFACE  = 3'd4
  } cfg_reg_e;

  // Enables for the back end
  typedef struct packed {
    logic boundary_en;
    logic surface_en;
  } ctrl_t;

  // One queued voxel: neighbors already zeroed where outside the volume
  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic [LW-1:0]            own;
    logic [NDIR-1:0][LW-1:0]  nb;      // -z,-y,-x,+x,+y,+z from bit 0
    logic [NDIR-1:0]          in_vol;
    logic                     on_edge;
  } entry_t;

endpackage

// ===== rtl/core/lfc_ram.sv =====
// ----------------------------------------------------------------------------
// lfc_ram
// Generic simple dual-port RAM, registered read, read-first on collision.
// ----------------------------------------------------------------------------
module lfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/lfc_cfg.sv =====
// ----------------------------------------------------------------------------
// lfc_cfg
// Configuration registers: clamped sizes, plane size product, enables.
// ----------------------------------------------------------------------------
module lfc_cfg #(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [2:0]                                cfg_idx_i,
  input  logic [lfc_pkg::CFG_W-1:0]                 cfg_wdata_i,
  output logic [$clog2(MAX_X+1)-1:0]                sx_o,
  output logic [$clog2(MAX_Y+1)-1:0]                sy_o,
  output logic [lfc_pkg::ZCW-1:0]                   sz_o,
  output logic [$clog2(MAX_X*MAX_Y+1)-1:0]          plane_o,
  output logic                                      restart_o,
  output lfc_pkg::ctrl_t                            ctrl_o
);
  import lfc_pkg::*;

  localparam int XCW = $clog2(MAX_X+1);
  localparam int YCW = $clog2(MAX_Y+1);
  localparam int PW  = $clog2(MAX_X*MAX_Y+1);

  logic [XCW-1:0] sx_q, sx_d, sx_cl;
  logic [YCW-1:0] sy_q, sy_d, sy_cl;
  logic [ZCW-1:0] sz_q, sz_d, sz_cl;
  logic [PW-1:0]  plane_q, plane_d;
  ctrl_t          ctrl_q, ctrl_d;
  logic [XRW-1:0] wx;

  assign wx = cfg_wdata_i[XRW-1:0];

  // clamp into the legal range
  always_comb begin
    if (wx == '0)                     sx_cl = XCW'(1);
    else if (32'(wx) > MAX_X)         sx_cl = XCW'(MAX_X);
    else                              sx_cl = XCW'(wx);
    if (wx == '0)                     sy_cl = YCW'(1);
    else if (32'(wx) > MAX_Y)         sy_cl = YCW'(MAX_Y);
    else                              sy_cl = YCW'(wx);
    if (cfg_wdata_i == '0)            sz_cl = ZCW'(1);
    else if (32'(cfg_wdata_i) > MAX_Z) sz_cl = ZCW'(MAX_Z);
    else                              sz_cl = cfg_wdata_i;
  end

  always_comb begin
    sx_d      = sx_q;
    sy_d      = sy_q;
    sz_d      = sz_q;
    plane_d   = plane_q;
    ctrl_d    = ctrl_q;
    restart_o = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: begin
          sx_d      = sx_cl;
          plane_d   = PW'(sx_cl * sy_q);
          restart_o = 1'b1;
        end
        CFG_SIZE_Y: begin
          sy_d      = sy_cl;
          plane_d   = PW'(sx_q * sy_cl);
          restart_o = 1'b1;
        end
        CFG_SIZE_Z: begin
          sz_d      = sz_cl;
          restart_o = 1'b1;
        end
        CFG_BOUNDARY: ctrl_d.boundary_en = cfg_wdata_i[0];
        CFG_SURFACE:  ctrl_d.surface_en  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q    <= XCW'(1);
      sy_q    <= YCW'(1);
      sz_q    <= ZCW'(1);
      plane_q <= PW'(1);
      ctrl_q  <= '0;
    end else begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sz_q    <= sz_d;
      plane_q <= plane_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign sz_o    = sz_q;
  assign plane_o = plane_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ===== rtl/core/lfc_front.sv =====
// ----------------------------------------------------------------------------
// lfc_front
// Accepts words, tracks stream position, keeps the two-plane label window
// and gathers the six neighbors of each voxel for the queue.
// ----------------------------------------------------------------------------
module lfc_front #(
  parameter int          MAX_X      = 256,
  parameter int          MAX_Y      = 256,
  parameter logic [15:0] LABEL_MASK = 16'hFFFF,
  parameter int          QDEPTH     = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lfc_pkg::LW-1:0]              in_label_i,
  input  logic                                in_pad_i,
  input  logic [$clog2(MAX_X+1)-1:0]          sx_i,
  input  logic [$clog2(MAX_Y+1)-1:0]          sy_i,
  input  logic [lfc_pkg::ZCW-1:0]             sz_i,
  input  logic [$clog2(MAX_X*MAX_Y+1)-1:0]    plane_i,
  input  logic                                restart_i,
  input  logic [$clog2(QDEPTH+1)-1:0]         q_count_i,
  output logic                                q_push_o,
  output lfc_pkg::entry_t                     q_entry_o
);
  import lfc_pkg::*;

  localparam int XW  = $clog2(MAX_X);
  localparam int YW  = $clog2(MAX_Y);
  localparam int XCW = $clog2(MAX_X+1);
  localparam int YCW = $clog2(MAX_Y+1);
  localparam int AW  = $clog2(2*MAX_X*MAX_Y);
  localparam int CW  = $clog2(QDEPTH+1) + 1;

  // stream position and coordinates
  logic [AW-1:0]    p_q, p_d;
  logic [XW-1:0]    ix_q, ix_d, ox_q, ox_d;
  logic [YW-1:0]    iy_q, iy_d, oy_q, oy_d;
  logic [ZW-1:0]    iz_q, iz_d, oz_q, oz_d;
  logic [IDX_W-1:0] c_q, c_d;
  logic             done_q, done_d, prime_q, prime_d;

  // stage 1 (RAM read in flight)
  logic             s1_valid_q, s1_emit_q, s1_bp1_q, s1_bpy_q, s1_edge_q;
  logic [NDIR-1:0]  s1_inside_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [LW-1:0]    s1_wlab_q;

  // center row shift: c+1 -> c -> c-1
  logic [LW-1:0]    own_q, cm1_q;

  logic             acc, live, step, emit, restart;
  logic             ix_last, iy_last, iz_last, ox_last, oy_last, oz_last;
  logic [LW-1:0]    wlab, cp1_val;
  logic [NDIR-1:0]  in_vol;
  logic             on_edge;
  logic [AW-1:0]    a_mz, a_my, a_p1, a_py, plane_a, sx_a;
  logic [LW-1:0]    rd_mz, rd_my, rd_p1, rd_py;

  assign in_ready_o = (CW'(q_count_i) + CW'(s1_valid_q)) < CW'(QDEPTH);
  assign acc  = in_valid_i && in_ready_o;
  assign live = !done_q;
  assign step = acc && !(live && in_pad_i);   // early pad dropped
  assign emit = step && prime_q;
  assign wlab = live ? (in_label_i & LABEL_MASK) : '0;

  assign ix_last = (XCW'(ix_q) + XCW'(1)) == sx_i;
  assign iy_last = (YCW'(iy_q) + YCW'(1)) == sy_i;
  assign iz_last = (ZCW'(iz_q) + ZCW'(1)) == sz_i;
  assign ox_last = (XCW'(ox_q) + XCW'(1)) == sx_i;
  assign oy_last = (YCW'(oy_q) + YCW'(1)) == sy_i;
  assign oz_last = (ZCW'(oz_q) + ZCW'(1)) == sz_i;

  assign in_vol  = {!oz_last, !oy_last, !ox_last, ox_q != '0, oy_q != '0, oz_q != '0};
  assign on_edge = ox_q == '0 || ox_last || oy_q == '0 || oy_last ||
                   (sz_i != ZCW'(1) && (oz_q == '0 || oz_last));

  // window addresses relative to the write position p
  assign plane_a = AW'(plane_i);
  assign sx_a    = AW'(sx_i);
  assign a_mz    = p_q - (plane_a << 1);
  assign a_my    = p_q - plane_a - sx_a;
  assign a_p1    = p_q - plane_a + AW'(1);
  assign a_py    = p_q - plane_a + sx_a;

  lfc_ram #(.WIDTH(LW), .DEPTH(2**AW)) u_ram_mz (
    .clk_i, .we_i(step), .waddr_i(p_q), .wdata_i(wlab), .raddr_i(a_mz), .rdata_o(rd_mz)
  );
  lfc_ram #(.WIDTH(LW), .DEPTH(2**AW)) u_ram_my (
    .clk_i, .we_i(step), .waddr_i(p_q), .wdata_i(wlab), .raddr_i(a_my), .rdata_o(rd_my)
  );
  lfc_ram #(.WIDTH(LW), .DEPTH(2**AW)) u_ram_p1 (
    .clk_i, .we_i(step), .waddr_i(p_q), .wdata_i(wlab), .raddr_i(a_p1), .rdata_o(rd_p1)
  );
  lfc_ram #(.WIDTH(LW), .DEPTH(2**AW)) u_ram_py (
    .clk_i, .we_i(step), .waddr_i(p_q), .wdata_i(wlab), .raddr_i(a_py), .rdata_o(rd_py)
  );

  // position update
  always_comb begin
    p_d     = p_q;
    ix_d    = ix_q;
    iy_d    = iy_q;
    iz_d    = iz_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    c_d     = c_q;
    done_d  = done_q;
    prime_d = prime_q;
    restart = restart_i || (emit && ox_last && oy_last && oz_last);
    if (step) begin
      p_d = p_q + AW'(1);
      if (live) begin
        if (!ix_last) begin
          ix_d = ix_q + XW'(1);
        end else begin
          ix_d = '0;
          if (!iy_last) begin
            iy_d = iy_q + YW'(1);
          end else begin
            iy_d    = '0;
            prime_d = 1'b1;
            if (iz_last) done_d = 1'b1;
            else         iz_d   = iz_q + ZW'(1);
          end
        end
      end
    end
    if (emit) begin
      c_d = c_q + IDX_W'(1);
      if (!ox_last) begin
        ox_d = ox_q + XW'(1);
      end else begin
        ox_d = '0;
        if (!oy_last) begin
          oy_d = oy_q + YW'(1);
        end else begin
          oy_d = '0;
          oz_d = oz_q + ZW'(1);
        end
      end
    end
    if (restart) begin
      p_d     = '0;
      ix_d    = '0;
      iy_d    = '0;
      iz_d    = '0;
      ox_d    = '0;
      oy_d    = '0;
      oz_d    = '0;
      c_d     = '0;
      done_d  = 1'b0;
      prime_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q        <= '0;
      ix_q       <= '0;
      iy_q       <= '0;
      iz_q       <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      oz_q       <= '0;
      c_q        <= '0;
      done_q     <= 1'b0;
      prime_q    <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      p_q        <= p_d;
      ix_q       <= ix_d;
      iy_q       <= iy_d;
      iz_q       <= iz_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      oz_q       <= oz_d;
      c_q        <= c_d;
      done_q     <= done_d;
      prime_q    <= prime_d;
      s1_valid_q <= step;
      s1_emit_q  <= emit;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_idx_q    <= c_q;
      s1_inside_q <= in_vol;
      s1_edge_q   <= on_edge;
      s1_wlab_q   <= wlab;
      s1_bp1_q    <= plane_i == '0 + 1'b1;
      s1_bpy_q    <= sy_i == YCW'(1);
    end
    if (s1_valid_q) begin
      own_q <= cp1_val;
      cm1_q <= own_q;
    end
  end

  // c+1 or c+sx equal to the word just written when the plane or row is thin
  assign cp1_val = s1_bp1_q ? s1_wlab_q : rd_p1;

  assign q_push_o          = s1_valid_q && s1_emit_q;
  assign q_entry_o.index   = s1_idx_q;
  assign q_entry_o.own     = own_q;
  assign q_entry_o.nb[0]   = s1_inside_q[0] ? rd_mz : '0;
  assign q_entry_o.nb[1]   = s1_inside_q[1] ? rd_my : '0;
  assign q_entry_o.nb[2]   = s1_inside_q[2] ? cm1_q : '0;
  assign q_entry_o.nb[3]   = s1_inside_q[3] ? cp1_val : '0;
  assign q_entry_o.nb[4]   = s1_inside_q[4] ? (s1_bpy_q ? s1_wlab_q : rd_py) : '0;
  assign q_entry_o.nb[5]   = s1_inside_q[5] ? s1_wlab_q : '0;
  assign q_entry_o.in_vol  = s1_inside_q;
  assign q_entry_o.on_edge = s1_edge_q;

endmodule

// ===== rtl/core/lfc_fifo.sv =====
// ----------------------------------------------------------------------------
// lfc_fifo
// Small flop queue between front and back end.
// ----------------------------------------------------------------------------
module lfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTW-1:0]   wr_q, rd_q;
  logic [CNW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PTW'(1);
      if (pop_i)  rd_q <= rd_q + PTW'(1);
      cnt_q <= cnt_q + CNW'(push_i) - CNW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== rtl/core/lfc_back.sv =====
// ----------------------------------------------------------------------------
// lfc_back
// Contact evaluation and output register.
// ----------------------------------------------------------------------------
module lfc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  lfc_pkg::entry_t             q_entry_i,
  output logic                        q_pop_o,
  input  lfc_pkg::ctrl_t              ctrl_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lfc_pkg::OUT_W-1:0]   out_data_o
);
  import lfc_pkg::*;

  logic                    ov_q;
  logic [IDX_W-1:0]        idx_q;
  logic [LW-1:0]           own_q;
  logic [2:0]              cnt_q, cnt;
  logic [NDIR-1:0]         dirs_q, dirs;
  logic [NDIR-1:0][LW-1:0] nb_q;
  logic                    surf_q, surf;

  assign q_pop_o = q_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      dirs[k] = q_entry_i.own != '0 && q_entry_i.in_vol[k] &&
                q_entry_i.nb[k] != '0 && q_entry_i.nb[k] != q_entry_i.own;
    end
    cnt  = ctrl_i.boundary_en ? 3'($countones(dirs)) : 3'd0;
    surf = ctrl_i.surface_en && q_entry_i.own != '0 && q_entry_i.on_edge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (q_pop_o) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      idx_q  <= q_entry_i.index;
      own_q  <= q_entry_i.own;
      cnt_q  <= cnt;
      dirs_q <= dirs;
      nb_q   <= q_entry_i.nb;
      surf_q <= surf;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {2'b00, surf_q, nb_q, dirs_q, cnt_q, own_q, idx_q};

endmodule

// ===== rtl/core/voxel_label_face_contact_scan.sv =====
// ----------------------------------------------------------------------------
// voxel_label_face_contact_scan
// 6-connected label contact scan over a raster-ordered 3D voxel stream.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Word contents (low bit first)
// s_axis    in   tdata: label_in[15:0]; tuser: mode (0 voxel, 1 pad)
// m_axis    out  tdata: voxel_index, own_label, contact_count, contact_dirs,
//                label -z,-y,-x,+x,+y,+z, on_outer_surface, 2 zero bits
// cfg       in   we / idx / wdata: size_x, size_y, size_z, boundary, surface
//
// One word per cycle sustained; the window RAMs take a write and a read
// every cycle and the four-entry queue absorbs back-end stalls.
// A voxel's result leaves once the word one plane later is taken, passing
// through the stage-1 register, the queue write and the output register.
// Reset is asynchronous; the label window needs no clearing pass since a
// neighbor is only read once it was written for the current volume.
// Writing a size register restarts the stream position.
// ----------------------------------------------------------------------------
module voxel_label_face_contact_scan #(
  parameter int MAX_X      = 256,
  parameter int MAX_Y      = 256,
  parameter int LABEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // label_in
  input  logic [0:0]                    s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lfc_pkg::OUT_W-1:0]     m_axis_tdata,  // see table above
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [lfc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import lfc_pkg::*;

  localparam int          QDEPTH    = 4;
  localparam logic [15:0] LabelMask = (LABEL_BITS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << LABEL_BITS) - 1);

  logic [$clog2(MAX_X+1)-1:0]       sx;
  logic [$clog2(MAX_Y+1)-1:0]       sy;
  logic [ZCW-1:0]                   sz;
  logic [$clog2(MAX_X*MAX_Y+1)-1:0] plane;
  logic                             restart;
  ctrl_t                            ctrl;

  logic                             q_push, q_pop;
  entry_t                           q_in, q_out;
  logic [$clog2(QDEPTH+1)-1:0]      q_count;

  lfc_cfg #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .sx_o(sx), .sy_o(sy), .sz_o(sz), .plane_o(plane),
    .restart_o(restart), .ctrl_o(ctrl)
  );

  lfc_front #(
    .MAX_X(MAX_X), .MAX_Y(MAX_Y), .LABEL_MASK(LabelMask), .QDEPTH(QDEPTH)
  ) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_label_i(s_axis_tdata), .in_pad_i(s_axis_tuser[0]),
    .sx_i(sx), .sy_i(sy), .sz_i(sz), .plane_i(plane), .restart_i(restart),
    .q_count_i(q_count), .q_push_o(q_push), .q_entry_o(q_in)
  );

  lfc_fifo #(.WIDTH($bits(entry_t)), .DEPTH(QDEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in),
    .pop_i(q_pop), .data_o(q_out), .count_o(q_count)
  );

  lfc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_count != '0), .q_entry_i(q_out), .q_pop_o(q_pop),
    .ctrl_i(ctrl),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata)
  );

  // the front's credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count != QDEPTH[$clog2(QDEPTH+1)-1:0] || q_pop))
    else $error("queue overflow");

  // count agrees with the direction mask when enabled
  a_count_dirs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ctrl.boundary_en) |->
      (32'(m_axis_tdata[46:44]) == $countones(m_axis_tdata[52:47])))
    else $error("contact count mismatch");

  // surface flag only on labelled voxels
  a_surf_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[149]) |-> (m_axis_tdata[43:28] != '0))
    else $error("surface flag on unlabelled voxel");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 6-connected voxel label contact scan.
// Labels stream through s_axis; a scoreboard keeps its own label window,
// predicts every result word and checks it field by field on m_axis.
// ----------------------------------------------------------------------------

// Scoreboard: tracks the stream position and the label window, and holds
// the expected result words in arrival order.
class contact_board;

  localparam int WIN = 2 * 256 * 256 + 1;

  typedef struct packed {
    logic [27:0]        idx;
    logic [15:0]        own;
    logic [2:0]         cnt;
    logic [5:0]         dirs;
    logic [5:0][15:0]   nb;     // -z at index 0 up to +z
    logic               surf;
  } contact_t;

  logic [15:0] win [WIN];
  longint      seen;
  int          col, row, pln;
  int          reg_x, reg_y, reg_z;
  bit          bnd_en, srf_en;
  contact_t    due [$];
  int          errors;
  int          checked;

  function new();
    foreach (win[i]) win[i] = '0;
    seen = 0; col = 0; row = 0; pln = 0;
    reg_x = 1; reg_y = 1; reg_z = 1;
    bnd_en = 0; srf_en = 0;
    errors = 0; checked = 0;
  endfunction

  function void note_config(logic [2:0] idx, logic [12:0] val);
    case (idx)
      lfc_pkg::CFG_SIZE_X:   begin reg_x = val[8:0]; seen = 0; col = 0; row = 0; pln = 0; end
      lfc_pkg::CFG_SIZE_Y:   begin reg_y = val[8:0]; seen = 0; col = 0; row = 0; pln = 0; end
      lfc_pkg::CFG_SIZE_Z:   begin reg_z = val; seen = 0; col = 0; row = 0; pln = 0; end
      lfc_pkg::CFG_BOUNDARY: bnd_en = val[0];
      lfc_pkg::CFG_SURFACE:  srf_en = val[0];
      default: ;
    endcase
  endfunction

  function longint clamp(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function logic [15:0] rd(longint pos);
    return win[pos % WIN];
  endfunction

  // One accepted input word: update window, queue the result it releases.
  function void note_input(bit pad, logic [15:0] lab);
    longint sx, sy, sz, plane, total, p, c;
    bit [5:0] in_vol;
    contact_t e;
    bit brd;
    sx = clamp(reg_x, 256); sy = clamp(reg_y, 256); sz = clamp(reg_z, 4096);
    plane = sx * sy; total = plane * sz; p = seen;
    if (p < total) begin
      if (pad) return;          // pad inside the volume is dropped
      win[p % WIN] = lab;
    end else begin
      win[p % WIN] = '0;        // past the end any word acts as a pad
    end
    seen = p + 1;
    if (p < plane) return;
    c = p - plane;
    e = '0;
    e.idx = c[27:0];
    e.own = rd(c);
    in_vol[0] = pln != 0;
    in_vol[1] = row != 0;
    in_vol[2] = col != 0;
    in_vol[3] = col + 1 < sx;
    in_vol[4] = row + 1 < sy;
    in_vol[5] = pln + 1 < sz;
    if (in_vol[0]) e.nb[0] = rd(c - plane);
    if (in_vol[1]) e.nb[1] = rd(c - sx);
    if (in_vol[2]) e.nb[2] = rd(c - 1);
    if (in_vol[3]) e.nb[3] = rd(c + 1);
    if (in_vol[4]) e.nb[4] = rd(c + sx);
    if (in_vol[5]) e.nb[5] = rd(c + plane);
    if (e.own != 0) begin
      for (int k = 0; k < 6; k++)
        if (in_vol[k] && e.nb[k] != 0 && e.nb[k] != e.own) begin
          e.dirs[k] = 1'b1;
          e.cnt++;
        end
      brd = col == 0 || col + 1 == sx || row == 0 || row + 1 == sy;
      if (sz != 1 && (pln == 0 || pln + 1 == sz)) brd = 1;
      e.surf = srf_en & brd;
    end
    if (!bnd_en) e.cnt = '0;
    due = {due, e};
    if (c + 1 >= total) begin
      seen = 0; col = 0; row = 0; pln = 0;
    end else begin
      col++;
      if (col >= sx) begin
        col = 0; row++;
        if (row >= sy) begin row = 0; pln++; end
      end
    end
  endfunction

  function void cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check(logic [151:0] w);
    contact_t e;
    if (due.size() == 0) begin
      $error("result word with nothing expected: %h", w);
      errors++;
      return;
    end
    e = due.pop_front();
    checked++;
    cmp("voxel_index", e.idx, w[27:0]);
    cmp("own_label", e.own, w[43:28]);
    cmp("contact_count", e.cnt, w[46:44]);
    cmp("contact_dirs", e.dirs, w[52:47]);
    cmp("label_minus_z", e.nb[0], w[68:53]);
    cmp("label_minus_y", e.nb[1], w[84:69]);
    cmp("label_minus_x", e.nb[2], w[100:85]);
    cmp("label_plus_x", e.nb[3], w[116:101]);
    cmp("label_plus_y", e.nb[4], w[132:117]);
    cmp("label_plus_z", e.nb[5], w[148:133]);
    cmp("on_outer_surface", e.surf, w[149]);
    cmp("pad_bits", 0, w[151:150]);
  endfunction

endclass

module tb_top;
  import lfc_pkg::*;

  localparam int WATCHDOG = 5000;   // idle cycles before giving up
  localparam int SETTLE   = 20;     // quiet cycles after the last result
  localparam int ITEMS    = 1650;   // input word budget

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;   // label_in
  logic [0:0]   s_axis_tuser = '0;   // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;        // index, own, count, dirs, 6 labels, surface
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [12:0]  cfg_wdata_i = '0;

  contact_board board = new();
  int idle_pct  = 0;   // sender gap odds, percent per word
  int stall_pct = 0;   // receiver stall odds, percent per cycle
  int words_in  = 0;
  int volumes   = 0;
  int quiet     = 0;

  voxel_label_face_contact_scan DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: sample handshakes at the edge, feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        board.note_config(cfg_idx_i, cfg_wdata_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_input(s_axis_tuser[0], s_axis_tdata);
        words_in <= words_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        board.check(m_axis_tdata);
      end
      if (cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(cfg_reg_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 13'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one word on s_axis; idling mix by progress, random gap first, held until taken
  task automatic send(bit pad, logic [15:0] lab);
    int phase;
    phase = (words_in * 4) / ITEMS;
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 49; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 13; stall_pct = 13; end
    endcase
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= pad;
    s_axis_tdata <= lab;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait for every expected word, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_label();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 85) return 16'($urandom_range(3, 1));   // few labels -> many contacts
    if (r < 90) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // one volume: set sizes and enables, stream voxels, flush with pads
  task automatic run_volume(int sx, int sy, int sz, int nvox, bit noisy);
    int plane;
    cfg_write(CFG_SIZE_X, sx);
    cfg_write(CFG_SIZE_Y, sy);
    cfg_write(CFG_SIZE_Z, sz);
    cfg_write(CFG_BOUNDARY, $urandom_range(1));
    cfg_write(CFG_SURFACE, $urandom_range(1));
    plane = (sx < 1 ? 1 : sx > 256 ? 256 : sx) * (sy < 1 ? 1 : sy > 256 ? 256 : sy);
    for (int i = 0; i < nvox; i++) begin
      if (noisy && $urandom_range(19) == 0) send(1'b1, 16'($urandom));   // dropped pad
      send(1'b0, rand_label());
    end
    // flush: a mix of pads and stray voxels, both act as pads here
    for (int i = 0; i < plane; i++) begin
      send(noisy ? 1'($urandom_range(1)) : 1'b1, 16'($urandom));
    end
    drain();
    volumes++;
  endtask

  initial begin
    int sx, sy, sz, tot;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sizes (1x1x1), label extremes
    send(1'b1, 16'hFFFF);               // pad before the volume is done: dropped
    send(1'b0, 16'hFFFF);
    send(1'b0, 16'h0000);               // voxel past the end flushes
    drain();
    cfg_write(cfg_reg_e'(3'd5), 13'h1FFF);   // unused indexes
    cfg_write(cfg_reg_e'(3'd7), 13'h1FFF);
    // 3x3x3 with all enables on, alternating labels for dense contacts
    cfg_write(CFG_BOUNDARY, 1);
    cfg_write(CFG_SURFACE, 1);
    cfg_write(CFG_SIZE_X, 3);
    cfg_write(CFG_SIZE_Y, 3);
    cfg_write(CFG_SIZE_Z, 3);
    for (int i = 0; i < 27; i++) send(1'b0, (i == 13) ? 16'd7 : (i % 2) ? 16'hFFFF : 16'd0);
    for (int i = 0; i < 9; i++) send(1'b1, 16'h0);
    drain();
    // size extremes: zero clamps up, oversize clamps down
    run_volume(0, 0, 0, 1, 0);
    run_volume(511, 1, 1, 256, 0);
    run_volume(1, 300, 1, 256, 0);
    run_volume(2, 2, 1, 4, 1);          // single plane: no z surface
    // deep volume, only the start streamed, then restarted by size writes
    cfg_write(CFG_SIZE_X, 1);
    cfg_write(CFG_SIZE_Y, 1);
    cfg_write(CFG_SIZE_Z, 13'h1FFF);
    for (int i = 0; i < 40; i++) send(1'b0, rand_label());
    drain();

    // Random volumes up to the word budget
    while (words_in < ITEMS) begin
      sx = $urandom_range(6, 1);
      sy = $urandom_range(6, 1);
      sz = $urandom_range(5, 1);
      tot = sx * sy * sz;
      run_volume(sx, sy, sz, tot, $urandom_range(3) == 0);
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();

    $display("Covered %0d volumes, %0d input words, %0d result words checked.",
             volumes, words_in, board.checked);
    $display("Sizes from 1 to 256 per axis plus clamping, all enable settings and idling mixes.");
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
